// File: src/adjacency_matrix_dfs_order_assert.svh
// assertion macros for the depth-first walk block
`ifndef ADJACENCY_MATRIX_DFS_ORDER_ASSERT_SVH
`define ADJACENCY_MATRIX_DFS_ORDER_ASSERT_SVH

// same-cycle implication
`define AMDFS_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("amdfs assertion failed");

// next-cycle implication
`define AMDFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("amdfs assertion failed");

`endif

// File: src/amdfs_pkg.sv
// package: types and constants of the depth-first walk block
`default_nettype none

package amdfs_pkg;

	localparam int MAX_NODES = 64;
	localparam int NODE_W    = 6;
	localparam int CNT_W     = 7;
	localparam int MODE_W    = 2;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} req_t;

	typedef struct packed {
		logic [NODE_W-1:0] visited_node;
		logic              last;
	} rsp_t;

endpackage

`default_nettype wire

// File: src/adjacency_matrix_dfs_order.sv
// top level: adjacency bit matrix with depth-first visit order walk
`default_nettype none
`include "adjacency_matrix_dfs_order_assert.svh"

// Keeps an undirected adjacency matrix of up to 64 nodes in a 64 x 64 bit
// memory with one valid bit per row, so reset clears it at once with no
// clearing pass. A request is taken when start is high and busy is low.
// An insert or remove does a read-modify-write of both rows through the
// single write port of the matrix memory; an out-of-range pair or an unused
// mode does nothing. A run does a row read, then a lowest-unvisited-neighbor
// pick, for each visited node, and a registered stack read, row read and
// pick for each backtrack. Each visited node appears on result for one
// cycle with result_valid high; the receiver cannot stall, so it must
// take every strobe. The final node of a walk carries last.

module adjacency_matrix_dfs_order (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire amdfs_pkg::req_t              request,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [amdfs_pkg::CNT_W-1:0] cfg_data,
	output logic                              result_valid,
	output amdfs_pkg::rsp_t                   result
);

	import amdfs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE_WRA,
		ST_EDGE_WRB,
		ST_ROW_RD,
		ST_PICK,
		ST_TOP
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     node_count_q;
	logic [NODE_W-1:0]    a_q;
	logic [NODE_W-1:0]    b_q;
	logic                 ins_q;
	logic [NODE_W-1:0]    top_q;
	logic [NODE_W-1:0]    pend_q;
	logic [CNT_W-1:0]     depth_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [MAX_NODES-1:0] row_valid_q;
	logic                 rvalid_q;
	logic                 result_valid_q;
	rsp_t                 result_q;

	logic                 accept;
	logic [CNT_W-1:0]     n_eff;
	logic                 in_range;
	logic [MAX_NODES-1:0] node_mask;
	logic [MAX_NODES-1:0] row_cur;
	logic [MAX_NODES-1:0] cand;
	logic [NODE_W-1:0]    pick;
	logic                 found;
	logic [MAX_NODES-1:0] edge_bit;
	logic [CNT_W-1:0]     depth_m2;

	logic                 adj_we;
	logic [NODE_W-1:0]    adj_waddr;
	logic [MAX_NODES-1:0] adj_wdata;
	logic [NODE_W-1:0]    adj_raddr;
	logic [MAX_NODES-1:0] adj_rdata;

	logic                 stk_we;
	logic [NODE_W-1:0]    stk_waddr;
	logic [NODE_W-1:0]    stk_wdata;
	logic [NODE_W-1:0]    stk_raddr;
	logic [NODE_W-1:0]    stk_rdata;

	assign accept    = start && (state_q == ST_IDLE);
	assign n_eff     = (node_count_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_q;
	assign in_range  = ({1'b0, request.node_a} < n_eff) && ({1'b0, request.node_b} < n_eff);
	assign row_cur   = rvalid_q ? adj_rdata : '0;
	assign cand      = row_cur & node_mask & ~visited_q;
	assign depth_m2  = depth_q - CNT_W'(2);

	always_comb begin
		for (int j = 0; j < MAX_NODES; j++) begin
			node_mask[j] = CNT_W'(j) < n_eff;
		end
	end

	// lowest set candidate
	always_comb begin
		pick  = '0;
		found = 1'b0;
		for (int j = MAX_NODES - 1; j >= 0; j--) begin
			if (cand[j]) begin
				pick  = NODE_W'(j);
				found = 1'b1;
			end
		end
	end

	always_comb begin
		edge_bit  = '0;
		adj_we    = 1'b0;
		adj_waddr = a_q;
		adj_raddr = top_q;
		stk_we    = 1'b0;
		stk_waddr = depth_q[NODE_W-1:0];
		stk_wdata = pick;
		stk_raddr = depth_m2[NODE_W-1:0];
		case (state_q)
			ST_IDLE: begin
				adj_raddr = request.node_a;
				stk_waddr = '0;
				stk_wdata = '0;
				stk_we    = accept && (request.mode == MODE_RUN);
			end
			ST_EDGE_WRA: begin
				edge_bit[b_q] = 1'b1;
				adj_we        = 1'b1;
				adj_waddr     = a_q;
				adj_raddr     = b_q;
			end
			ST_EDGE_WRB: begin
				edge_bit[a_q] = 1'b1;
				adj_we        = 1'b1;
				adj_waddr     = b_q;
			end
			ST_PICK: begin
				stk_we = found && (depth_q < CNT_W'(MAX_NODES));
			end
			default: begin
			end
		endcase
		adj_wdata = ins_q ? (row_cur | edge_bit) : (row_cur & ~edge_bit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			node_count_q   <= '0;
			depth_q        <= '0;
			visited_q      <= '0;
			row_valid_q    <= '0;
			rvalid_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			rvalid_q       <= row_valid_q[adj_raddr];
			if (adj_we) begin
				row_valid_q[adj_waddr] <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						a_q   <= request.node_a;
						b_q   <= request.node_b;
						ins_q <= (request.mode == MODE_INSERT);
						if ((request.mode == MODE_INSERT || request.mode == MODE_REMOVE)
							&& in_range) begin
							state_q <= ST_EDGE_WRA;
						end else if (request.mode == MODE_RUN) begin
							visited_q    <= MAX_NODES'(1);
							depth_q      <= CNT_W'(1);
							top_q        <= '0;
							pend_q       <= '0;
							state_q      <= ST_ROW_RD;
						end
					end
				end
				ST_EDGE_WRA: begin
					state_q <= ST_EDGE_WRB;
				end
				ST_EDGE_WRB: begin
					state_q <= ST_IDLE;
				end
				ST_ROW_RD: begin
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					if (found && (depth_q < CNT_W'(MAX_NODES))) begin
						visited_q[pick]       <= 1'b1;
						depth_q               <= depth_q + CNT_W'(1);
						top_q                 <= pick;
						pend_q                <= pick;
						result_q.visited_node <= pend_q;
						result_q.last         <= 1'b0;
						result_valid_q        <= 1'b1;
						state_q               <= ST_ROW_RD;
					end else if (depth_q == CNT_W'(1)) begin
						// walk finished
						depth_q               <= '0;
						visited_q             <= '0;
						result_q.visited_node <= pend_q;
						result_q.last         <= 1'b1;
						result_valid_q        <= 1'b1;
						state_q               <= ST_IDLE;
					end else begin
						depth_q <= depth_q - CNT_W'(1);
						state_q <= ST_TOP;
					end
				end
				ST_TOP: begin
					top_q   <= stk_rdata;
					state_q <= ST_ROW_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	amdfs_ram #(
		.WIDTH(MAX_NODES),
		.DEPTH(MAX_NODES)
	) u_adj_ram (
		.clk  (clk),
		.we   (adj_we),
		.waddr(adj_waddr),
		.wdata(adj_wdata),
		.raddr(adj_raddr),
		.rdata(adj_rdata)
	);

	amdfs_ram #(
		.WIDTH(NODE_W),
		.DEPTH(MAX_NODES)
	) u_stack_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	`AMDFS_ASSERT_IMPLIES(a_depth_bound, 1'b1, depth_q <= CNT_W'(MAX_NODES))
	`AMDFS_ASSERT_NEXT(a_run_goes_busy, start && !busy && request.mode == MODE_RUN, busy)
	`AMDFS_ASSERT_IMPLIES(a_last_ends_walk, result_valid && result.last, !busy)
	`AMDFS_ASSERT_IMPLIES(a_mid_result_busy, result_valid && !result.last, busy)
	`AMDFS_ASSERT_IMPLIES(a_idle_marks_clear, state_q == ST_IDLE, visited_q == '0)

endmodule

`default_nettype wire

// File: src/amdfs_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module amdfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
